// ===== rtl/core/torwl_pkg.sv =====
// Package for the ticket-ordered reader-writer lock.
// Holds mode and event codes and the result payload type; no dependencies.
`timescale 1ns / 1ps

package torwl_pkg;

  localparam logic [2:0] MODE_ACQ_EX  = 3'd0;
  localparam logic [2:0] MODE_ACQ_SH  = 3'd1;
  localparam logic [2:0] MODE_REL     = 3'd2;
  localparam logic [2:0] MODE_REL_SH  = 3'd3;
  localparam logic [2:0] MODE_TRY     = 3'd4;
  localparam logic [2:0] MODE_ABORT   = 3'd5;

  localparam logic [2:0] EV_GRANTED    = 3'd0;
  localparam logic [2:0] EV_QUEUED     = 3'd1;
  localparam logic [2:0] EV_REFUSED    = 3'd2;
  localparam logic [2:0] EV_DONE       = 3'd3;
  localparam logic [2:0] EV_FROM_QUEUE = 3'd4;
  localparam logic [2:0] EV_ABORTED    = 3'd5;
  localparam logic [2:0] EV_ERROR      = 3'd6;

  localparam int MODE_W   = 3;
  localparam int REQ_W    = 4;
  localparam int TICKET_W = 64;
  localparam int EVENT_W  = 3;
  localparam int WCOUNT_W = 4;

  typedef struct packed {
    logic [REQ_W-1:0]    target;
    logic [EVENT_W-1:0]  event_res;
    logic [WCOUNT_W-1:0] waiting_count;
    logic                last;
  } result_t;

endpackage

// ===== rtl/core/torwl_if.sv =====
// Valid/ready channel interfaces for the lock manager.
// Depends on torwl_pkg for field widths.
`timescale 1ns / 1ps

interface torwl_req_if
  import torwl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [REQ_W-1:0]    requester;
  logic [TICKET_W-1:0] ticket;
  modport source (output valid, mode, requester, ticket, input ready);
  modport sink (input valid, mode, requester, ticket, output ready);
endinterface

interface torwl_res_if
  import torwl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    target;
  logic [EVENT_W-1:0]  event_res;
  logic [WCOUNT_W-1:0] waiting_count;
  logic                last;
  modport source (output valid, target, event_res, waiting_count, last, input ready);
  modport sink (input valid, target, event_res, waiting_count, last, output ready);
endinterface

// ===== rtl/core/torwl_out_reg.sv =====
// Output register for result transactions of the lock manager.
// Depends on torwl_pkg and torwl_res_if.
`timescale 1ns / 1ps

module torwl_out_reg
  import torwl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  torwl_res_if.source out
);

  logic    valid_r;
  result_t data_r;

  assign can_push = !valid_r || out.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_push) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (can_push && push) begin
      data_r <= push_data;
    end
  end

  assign out.valid         = valid_r;
  assign out.target        = data_r.target;
  assign out.event_res     = data_r.event_res;
  assign out.waiting_count = data_r.waiting_count;
  assign out.last          = data_r.last;

endmodule

// ===== rtl/core/ticket_ordered_reader_writer_lock.sv =====
// Top level of the ticket-ordered reader-writer lock manager: sequencer,
// lock state, waiting queue and one shared ticket comparator.
// Depends on torwl_pkg, torwl_if and torwl_out_reg.
//
//   channel | dir | fields
//   in      | in  | mode, requester, ticket
//   out     | out | target, event_res, waiting_count, last
//
// A plain request passes through idle, a reader counter scan, a queue check,
// decide and emit; the input is not ready again until the sequencer is idle.
// A queue insert adds a position scan and a shift. A grant adds a count of the
// readers at the queue head, then one result per waiter taken from the queue.
// An abort skips both scans. A release shared that frees the last reader scans
// the counters and the queue once more. Each result waits for a free output
// register, so a stalled sink holds the sequencer. After reset the queue is empty.
`timescale 1ns / 1ps

module ticket_ordered_reader_writer_lock
  import torwl_pkg::*;
#(
  parameter int AGENTS      = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int COUNT_BITS  = 8
) (
  input logic clk,
  input logic rst_n,
  torwl_req_if.sink   in_ch,
  torwl_res_if.source out_ch
);

  localparam int AW = (AGENTS > 1) ? $clog2(AGENTS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(AGENTS + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_QCHK, S_DECIDE, S_INS_SCAN, S_INS_SHIFT,
    S_GCNT, S_GRANT, S_ABORT, S_EMIT
  } state_t;

  state_t state_r;
  logic [MODE_W-1:0] mode_r;
  logic [REQ_W-1:0] req_r;
  logic [TICKET_W-1:0] tkt_r;
  logic owner_valid_r;
  logic [REQ_W-1:0] owner_id_r;
  logic [COUNT_BITS-1:0] depth_r;
  logic [COUNT_BITS-1:0] rcnt_r [AGENTS];
  logic [TICKET_W-1:0] wt_r [QUEUE_DEPTH];
  logic [REQ_W-1:0] wa_r [QUEUE_DEPTH];
  logic wrd_r [QUEUE_DEPTH];
  logic [LW-1:0] len_r;
  logic [SW-1:0] scan_r;
  logic any_rd_r;
  logic [LW-1:0] pos_r;
  logic queued_r, wwait_r;
  logic [EVENT_W-1:0] ev_r;
  logic ins_rd_r;
  logic regrant_r;
  logic [LW-1:0] fin_len_r;

  result_t push_data;
  logic push, can_push;

  torwl_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .can_push(can_push), .out(out_ch)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  logic req_ok;
  logic [AW-1:0] req_idx;
  logic [COUNT_BITS-1:0] my_cnt;
  logic is_owner;
  logic tkt_gt;
  logic [QW-1:0] pos_idx;

  assign req_ok   = ({{(32-REQ_W){1'b0}}, req_r} < AGENTS);
  assign req_idx  = AW'(req_r);
  assign my_cnt   = req_ok ? rcnt_r[req_idx] : '0;
  assign is_owner = owner_valid_r && (owner_id_r == req_r);
  assign pos_idx  = QW'(pos_r);
  assign tkt_gt   = wt_r[pos_idx] > tkt_r;

  logic head_ok;
  logic [REQ_W-1:0] head_a;
  logic [AW-1:0] head_idx;
  assign head_ok  = ({{(32-REQ_W){1'b0}}, wa_r[0]} < AGENTS);
  assign head_a   = wa_r[0];
  assign head_idx = AW'(head_a);

  assign push = (state_r == S_EMIT) ||
                ((state_r == S_ABORT || state_r == S_GRANT) && len_r != '0 &&
                 (state_r == S_ABORT || wrd_r[0] ||
                  (!owner_valid_r && !any_rd_r)) &&
                 !(state_r == S_GRANT && owner_valid_r));

  // Every result of a request carries the final queue length. Results sent to
  // waiters use the length worked out before the grant pass starts, or zero on abort.
  always_comb begin
    if (state_r == S_EMIT) begin
      push_data.target        = req_r;
      push_data.event_res     = ev_r;
      push_data.waiting_count = WCOUNT_W'(len_r);
      push_data.last          = 1'b1;
    end else begin
      push_data.target        = head_a;
      push_data.event_res     = (state_r == S_ABORT) ? EV_ABORTED : EV_FROM_QUEUE;
      push_data.waiting_count = WCOUNT_W'(fin_len_r);
      push_data.last          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      owner_valid_r <= 1'b0;
      owner_id_r    <= '0;
      depth_r       <= '0;
      len_r         <= '0;
      for (int i = 0; i < AGENTS; i++) rcnt_r[i] <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r    <= in_ch.mode;
            req_r     <= in_ch.requester;
            tkt_r     <= in_ch.ticket;
            scan_r    <= '0;
            any_rd_r  <= 1'b0;
            pos_r     <= '0;
            queued_r  <= 1'b0;
            wwait_r   <= 1'b0;
            regrant_r <= 1'b0;
            fin_len_r <= '0;
            state_r   <= (in_ch.mode == MODE_ABORT) ? S_ABORT : S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (scan_r == SW'(AGENTS)) begin
            state_r <= S_QCHK;
          end else begin
            if (rcnt_r[AW'(scan_r)] != '0) any_rd_r <= 1'b1;
            scan_r <= scan_r + 1'b1;
          end
        end
        S_QCHK: begin
          if (pos_r == len_r) begin
            pos_r   <= '0;
            state_r <= S_DECIDE;
          end else begin
            if (wa_r[pos_idx] == req_r) queued_r <= 1'b1;
            if (!wrd_r[pos_idx]) wwait_r <= 1'b1;
            pos_r <= pos_r + 1'b1;
          end
        end
        S_DECIDE: begin
          if (regrant_r) begin
            ev_r    <= EV_DONE;
            state_r <= any_rd_r ? S_EMIT : S_GCNT;
          end else if (mode_r > MODE_ABORT || !req_ok || queued_r) begin
            ev_r    <= EV_ERROR;
            state_r <= S_EMIT;
          end else begin
            case (mode_r)
              MODE_ACQ_EX, MODE_ACQ_SH, MODE_TRY: begin
                if (is_owner) begin
                  state_r <= S_EMIT;
                  if (depth_r == CMAX) ev_r <= EV_ERROR;
                  else begin
                    depth_r <= depth_r + 1'b1;
                    ev_r    <= EV_GRANTED;
                  end
                end else if (mode_r == MODE_TRY) begin
                  state_r <= S_EMIT;
                  if (owner_valid_r || any_rd_r) ev_r <= EV_REFUSED;
                  else begin
                    owner_valid_r <= 1'b1;
                    owner_id_r    <= req_r;
                    depth_r       <= COUNT_BITS'(1);
                    ev_r          <= EV_GRANTED;
                  end
                end else if (my_cnt != '0) begin
                  state_r <= S_EMIT;
                  if (mode_r == MODE_ACQ_EX || my_cnt == CMAX) ev_r <= EV_ERROR;
                  else begin
                    rcnt_r[req_idx] <= my_cnt + 1'b1;
                    ev_r            <= EV_GRANTED;
                  end
                end else if (mode_r == MODE_ACQ_EX && !owner_valid_r && !any_rd_r) begin
                  owner_valid_r <= 1'b1;
                  owner_id_r    <= req_r;
                  depth_r       <= COUNT_BITS'(1);
                  ev_r          <= EV_GRANTED;
                  state_r       <= S_EMIT;
                end else if (mode_r == MODE_ACQ_SH && !owner_valid_r && !wwait_r) begin
                  rcnt_r[req_idx] <= COUNT_BITS'(1);
                  ev_r            <= EV_GRANTED;
                  state_r         <= S_EMIT;
                end else if (len_r == LW'(QUEUE_DEPTH)) begin
                  ev_r    <= EV_ERROR;
                  state_r <= S_EMIT;
                end else begin
                  ins_rd_r <= (mode_r == MODE_ACQ_SH);
                  ev_r     <= EV_QUEUED;
                  pos_r    <= '0;
                  state_r  <= S_INS_SCAN;
                end
              end
              MODE_REL, MODE_REL_SH: begin
                if (is_owner) begin
                  ev_r <= EV_DONE;
                  if (depth_r <= COUNT_BITS'(1)) begin
                    depth_r       <= '0;
                    owner_valid_r <= 1'b0;
                    owner_id_r    <= '0;
                    state_r       <= S_GCNT;
                  end else begin
                    depth_r <= depth_r - 1'b1;
                    state_r <= S_EMIT;
                  end
                end else if (mode_r == MODE_REL_SH && my_cnt != '0) begin
                  rcnt_r[req_idx] <= my_cnt - 1'b1;
                  ev_r            <= EV_DONE;
                  if (my_cnt == COUNT_BITS'(1)) begin
                    any_rd_r  <= 1'b0;
                    scan_r    <= '0;
                    regrant_r <= 1'b1;
                    state_r   <= S_SCAN_RD;
                  end else begin
                    state_r <= S_EMIT;
                  end
                end else begin
                  ev_r    <= EV_ERROR;
                  state_r <= S_EMIT;
                end
              end
              default: begin
                ev_r    <= EV_ERROR;
                state_r <= S_EMIT;
              end
            endcase
          end
        end
        S_INS_SCAN: begin
          if (pos_r == len_r || tkt_gt) begin
            scan_r  <= SW'(len_r);
            state_r <= S_INS_SHIFT;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        S_INS_SHIFT: begin
          for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
            if (LW'(i) > pos_r && LW'(i) <= len_r) begin
              wt_r[i]  <= wt_r[i-1];
              wa_r[i]  <= wa_r[i-1];
              wrd_r[i] <= wrd_r[i-1];
            end
          end
          wt_r[pos_idx]  <= tkt_r;
          wa_r[pos_idx]  <= req_r;
          wrd_r[pos_idx] <= ins_rd_r;
          len_r          <= len_r + 1'b1;
          state_r        <= S_EMIT;
        end
        S_GCNT: begin
          if (pos_r == len_r || !wrd_r[pos_idx]) begin
            if (owner_valid_r) fin_len_r <= len_r;
            else if (pos_r != '0) fin_len_r <= len_r - pos_r;
            else if (len_r != '0 && !any_rd_r) fin_len_r <= len_r - 1'b1;
            else fin_len_r <= len_r;
            state_r <= S_GRANT;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        S_GRANT, S_ABORT: begin
          if (len_r == '0 || (state_r == S_GRANT && owner_valid_r) ||
              (state_r == S_GRANT && !wrd_r[0] && any_rd_r)) begin
            if (state_r == S_ABORT) ev_r <= EV_DONE;
            state_r <= S_EMIT;
          end else if (can_push) begin
            if (state_r == S_GRANT) begin
              if (!wrd_r[0]) begin
                owner_valid_r <= 1'b1;
                owner_id_r    <= head_a;
                depth_r       <= COUNT_BITS'(1);
                state_r       <= S_EMIT;
              end else begin
                any_rd_r <= 1'b1;
                if (head_ok && rcnt_r[head_idx] == '0) begin
                  rcnt_r[head_idx] <= COUNT_BITS'(1);
                end
              end
            end
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              wt_r[i]  <= wt_r[i+1];
              wa_r[i]  <= wa_r[i+1];
              wrd_r[i] <= wrd_r[i+1];
            end
            len_r <= len_r - 1'b1;
          end
        end
        S_EMIT: begin
          if (can_push) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
